/* src/oat_pkg.sv */
// Shared types and constants for the ordered array table.
// Holds the operation codes and the controller/datapath command and status structs.
// Depends on nothing; every other file refers to it by scoped names.
package oat_pkg;

   localparam int DEPTH      = 16;
   localparam int ENTRY_BITS = 8;

   // Widths fixed by the external interface.
   localparam int OP_BITS    = 2;
   localparam int ELEM_BITS  = 8;
   localparam int POS_BITS   = 5;
   localparam int CAP_BITS   = 5;
   localparam int FOUND_BITS = 4;
   localparam int CNT_BITS   = 5;

   localparam int IDX_BITS   = $clog2(DEPTH);
   localparam int COUNT_BITS = $clog2(DEPTH + 1);
   localparam int WIDE_BITS  = ((COUNT_BITS > CAP_BITS) ? COUNT_BITS : CAP_BITS);
   localparam int CMP_BITS   = ((WIDE_BITS > POS_BITS) ? WIDE_BITS : POS_BITS) + 1;

   localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

   typedef enum logic [OP_BITS-1:0] {
      OP_APPEND = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2,
      OP_SEARCH = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      PTR_HOLD,
      PTR_COUNT_M1,
      PTR_POS_P1,
      PTR_ZERO,
      PTR_INC,
      PTR_DEC
   } ptr_op_type;

   typedef enum logic [1:0] {
      WA_COUNT,
      WA_PTR,
      WA_PTR_P1,
      WA_PTR_M1
   } wr_addr_type;

   typedef enum logic [1:0] {
      WD_ELEM,
      WD_RDATA,
      WD_PREV
   } wr_data_type;

   typedef struct packed {
      logic        load;
      ptr_op_type  ptr_op;
      logic        wr_en;
      wr_addr_type wr_addr_sel;
      wr_data_type wr_data_sel;
      logic        count_inc;
      logic        count_dec;
      logic        set_ok;
      logic        set_hit;
      logic        prev_load;
      logic        rsp_load;
   } oat_cmd_type;

   typedef struct packed {
      op_type op;
      logic   full;
      logic   pos_le_count;
      logic   pos_lt_count;
      logic   pos_last;
      logic   count_zero;
      logic   ptr_at_pos;
      logic   ptr_last;
      logic   ptr_zero;
      logic   match;
      logic   rsp_free;
   } oat_status_type;

endpackage

/* src/oat_ctrl.sv */
// Controller state machine for the ordered array table.
// Sequences append, insert, delete and search over the datapath; uses oat_pkg.
module oat_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  oat_pkg::oat_status_type status,
   output oat_pkg::oat_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_SHIFT_UP,
      ST_PLACE,
      ST_SHIFT_DOWN,
      ST_SCAN,
      ST_SWAP,
      ST_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      cmd             = '0;
      cmd.ptr_op      = oat_pkg::PTR_HOLD;
      cmd.wr_addr_sel = oat_pkg::WA_COUNT;
      cmd.wr_data_sel = oat_pkg::WD_ELEM;
      state_in        = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_START;
            end
         end
         ST_START: begin
            state_in = ST_FINISH;
            case (status.op)
               oat_pkg::OP_APPEND: begin
                  if (!status.full) begin
                     cmd.wr_en     = 1'b1;
                     cmd.count_inc = 1'b1;
                     cmd.set_ok    = 1'b1;
                  end
               end
               oat_pkg::OP_INSERT: begin
                  if (!status.full && status.pos_le_count) begin
                     if (!status.pos_lt_count) begin
                        // Insert at the end is an append.
                        cmd.wr_en     = 1'b1;
                        cmd.count_inc = 1'b1;
                        cmd.set_ok    = 1'b1;
                     end else begin
                        cmd.ptr_op = oat_pkg::PTR_COUNT_M1;
                        state_in   = ST_SHIFT_UP;
                     end
                  end
               end
               oat_pkg::OP_DELETE: begin
                  if (status.pos_lt_count) begin
                     if (status.pos_last) begin
                        cmd.count_dec = 1'b1;
                        cmd.set_ok    = 1'b1;
                     end else begin
                        cmd.ptr_op = oat_pkg::PTR_POS_P1;
                        state_in   = ST_SHIFT_DOWN;
                     end
                  end
               end
               default: begin
                  if (!status.count_zero) begin
                     cmd.ptr_op = oat_pkg::PTR_ZERO;
                     state_in   = ST_SCAN;
                  end
               end
            endcase
         end
         ST_SHIFT_UP: begin
            cmd.wr_en       = 1'b1;
            cmd.wr_addr_sel = oat_pkg::WA_PTR_P1;
            cmd.wr_data_sel = oat_pkg::WD_RDATA;
            if (status.ptr_at_pos) begin
               state_in = ST_PLACE;
            end else begin
               cmd.ptr_op = oat_pkg::PTR_DEC;
            end
         end
         ST_PLACE: begin
            cmd.wr_en       = 1'b1;
            cmd.wr_addr_sel = oat_pkg::WA_PTR;
            cmd.count_inc   = 1'b1;
            cmd.set_ok      = 1'b1;
            state_in        = ST_FINISH;
         end
         ST_SHIFT_DOWN: begin
            cmd.wr_en       = 1'b1;
            cmd.wr_addr_sel = oat_pkg::WA_PTR_M1;
            cmd.wr_data_sel = oat_pkg::WD_RDATA;
            if (status.ptr_last) begin
               cmd.count_dec = 1'b1;
               cmd.set_ok    = 1'b1;
               state_in      = ST_FINISH;
            end else begin
               cmd.ptr_op = oat_pkg::PTR_INC;
            end
         end
         ST_SCAN: begin
            cmd.prev_load = 1'b1;
            if (status.match) begin
               cmd.set_ok  = 1'b1;
               cmd.set_hit = 1'b1;
               if (status.ptr_zero) begin
                  state_in = ST_FINISH;
               end else begin
                  // The entry before the hit moves up into the hit's slot.
                  cmd.wr_en       = 1'b1;
                  cmd.wr_addr_sel = oat_pkg::WA_PTR;
                  cmd.wr_data_sel = oat_pkg::WD_PREV;
                  state_in        = ST_SWAP;
               end
            end else if (status.ptr_last) begin
               state_in = ST_FINISH;
            end else begin
               cmd.ptr_op = oat_pkg::PTR_INC;
            end
         end
         ST_SWAP: begin
            cmd.wr_en       = 1'b1;
            cmd.wr_addr_sel = oat_pkg::WA_PTR_M1;
            state_in        = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* src/oat_datapath.sv */
// Datapath for the ordered array table: entry memory, count, capacity and result register.
// Executes the commands of oat_ctrl and reports status back; uses oat_pkg.
module oat_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [oat_pkg::OP_BITS-1:0]          req_operation,
   input  logic [oat_pkg::ELEM_BITS-1:0]        req_element,
   input  logic [oat_pkg::POS_BITS-1:0]         req_position,
   input  logic                                 csr_wr_en,
   input  logic [oat_pkg::CAP_BITS-1:0]         csr_wr_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_ok,
   output logic [oat_pkg::FOUND_BITS-1:0]       rsp_found_at,
   output logic [oat_pkg::CNT_BITS-1:0]         rsp_entry_count,
   input  oat_pkg::oat_cmd_type                 cmd,
   output oat_pkg::oat_status_type              status
);

   logic [oat_pkg::ENTRY_BITS-1:0] mem [oat_pkg::DEPTH];

   oat_pkg::op_type                 op_ff;
   logic [oat_pkg::ENTRY_BITS-1:0]  elem_ff;
   logic [oat_pkg::POS_BITS-1:0]    pos_ff;
   logic [oat_pkg::COUNT_BITS-1:0]  count_ff;
   logic [oat_pkg::CAP_BITS-1:0]    capacity_ff;
   logic [oat_pkg::IDX_BITS-1:0]    ptr_ff;
   logic [oat_pkg::IDX_BITS-1:0]    ptr_in;
   logic [oat_pkg::ENTRY_BITS-1:0]  rdata_ff;
   logic [oat_pkg::ENTRY_BITS-1:0]  prev_ff;
   logic                            ok_ff;
   logic [oat_pkg::IDX_BITS-1:0]    hit_ff;
   logic                            rsp_valid_ff;
   logic                            rsp_ok_ff;
   logic [oat_pkg::FOUND_BITS-1:0]  rsp_found_ff;
   logic [oat_pkg::CNT_BITS-1:0]    rsp_count_ff;

   logic [oat_pkg::IDX_BITS-1:0]    wr_addr;
   logic [oat_pkg::ENTRY_BITS-1:0]  wr_data;
   logic [oat_pkg::CMP_BITS-1:0]    cnt_w;
   logic [oat_pkg::CMP_BITS-1:0]    cap_w;
   logic [oat_pkg::CMP_BITS-1:0]    depth_w;
   logic [oat_pkg::CMP_BITS-1:0]    limit_w;
   logic [oat_pkg::CMP_BITS-1:0]    pos_w;
   logic [oat_pkg::CMP_BITS-1:0]    ptr_w;

   assign cnt_w   = oat_pkg::CMP_BITS'(count_ff);
   assign cap_w   = oat_pkg::CMP_BITS'(capacity_ff);
   assign depth_w = oat_pkg::CMP_BITS'(oat_pkg::DEPTH);
   assign limit_w = (cap_w > depth_w) ? depth_w : cap_w;
   assign pos_w   = oat_pkg::CMP_BITS'(pos_ff);
   assign ptr_w   = oat_pkg::CMP_BITS'(ptr_ff);

   always_comb begin
      status              = '0;
      status.op           = op_ff;
      status.full         = (cnt_w >= limit_w);
      status.pos_le_count = (pos_w <= cnt_w);
      status.pos_lt_count = (pos_w < cnt_w);
      status.pos_last     = ((pos_w + oat_pkg::CMP_BITS'(1)) == cnt_w);
      status.count_zero   = (count_ff == '0);
      status.ptr_at_pos   = (ptr_w == pos_w);
      status.ptr_last     = ((ptr_w + oat_pkg::CMP_BITS'(1)) == cnt_w);
      status.ptr_zero     = (ptr_ff == '0);
      status.match        = (rdata_ff == elem_ff);
      status.rsp_free     = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      case (cmd.ptr_op)
         oat_pkg::PTR_COUNT_M1:
            ptr_in = oat_pkg::IDX_BITS'(count_ff - oat_pkg::COUNT_BITS'(1));
         oat_pkg::PTR_POS_P1:
            ptr_in = oat_pkg::IDX_BITS'(pos_ff + oat_pkg::POS_BITS'(1));
         oat_pkg::PTR_ZERO: ptr_in = '0;
         oat_pkg::PTR_INC:  ptr_in = ptr_ff + oat_pkg::IDX_BITS'(1);
         oat_pkg::PTR_DEC:  ptr_in = ptr_ff - oat_pkg::IDX_BITS'(1);
         default:           ptr_in = ptr_ff;
      endcase
   end

   always_comb begin
      case (cmd.wr_addr_sel)
         oat_pkg::WA_PTR:    wr_addr = ptr_ff;
         oat_pkg::WA_PTR_P1: wr_addr = ptr_ff + oat_pkg::IDX_BITS'(1);
         oat_pkg::WA_PTR_M1: wr_addr = ptr_ff - oat_pkg::IDX_BITS'(1);
         default:            wr_addr = oat_pkg::IDX_BITS'(count_ff);
      endcase
   end

   always_comb begin
      case (cmd.wr_data_sel)
         oat_pkg::WD_RDATA: wr_data = rdata_ff;
         oat_pkg::WD_PREV:  wr_data = prev_ff;
         default:           wr_data = elem_ff;
      endcase
   end

   // Single-port-write memory with a registered read. The read follows the
   // next pointer, so rdata_ff holds the entry at ptr_ff as it was before any write in that cycle.
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[ptr_in];
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      if (cmd.load) begin
         op_ff   <= oat_pkg::op_type'(req_operation);
         elem_ff <= oat_pkg::ENTRY_BITS'(req_element);
         pos_ff  <= req_position;
      end
      if (cmd.prev_load) begin
         prev_ff <= rdata_ff;
      end
      if (cmd.set_hit) begin
         hit_ff <= ptr_ff;
      end else if (cmd.load) begin
         hit_ff <= '0;
      end
      if (cmd.rsp_load) begin
         rsp_ok_ff    <= ok_ff;
         rsp_found_ff <= oat_pkg::FOUND_BITS'(hit_ff);
         rsp_count_ff <= oat_pkg::CNT_BITS'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         capacity_ff  <= oat_pkg::CAP_RESET;
         ok_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
         if (cmd.count_inc) begin
            count_ff <= count_ff + oat_pkg::COUNT_BITS'(1);
         end else if (cmd.count_dec) begin
            count_ff <= count_ff - oat_pkg::COUNT_BITS'(1);
         end
         if (cmd.set_ok) begin
            ok_ff <= 1'b1;
         end else if (cmd.load) begin
            ok_ff <= 1'b0;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_found_at    = rsp_found_ff;
   assign rsp_entry_count = rsp_count_ff;

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= oat_pkg::COUNT_BITS'(oat_pkg::DEPTH))
      else $error("entry count exceeds the table depth");

   a_grow_below_limit: assert property (@(posedge clock) disable iff (reset)
      cmd.count_inc |-> !status.full)
      else $error("list grew past its capacity");

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> status.rsp_free)
      else $error("result register overwritten while still pending");

   a_shrink_not_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.count_dec |-> !status.count_zero)
      else $error("delete on an empty list");

   a_hit_reported_ok: assert property (@(posedge clock) disable iff (reset)
      cmd.set_hit |=> ok_ff)
      else $error("search hit recorded without success flag");

endmodule

/* src/ordered_array_table_top.sv */
// Sequence: a transaction is accepted while idle, decoded in the start state, and its result
// is loaded into the result register from the finish state once that register is free; in
// between, insert and delete move the entries in turn (insert then places the new entry),
// and search compares entries in turn and swaps a hit one place toward the front.
// Throughput: one at a time; a new request is taken the cycle after the result is loaded.
// Reset: synchronous; count clears to 0 and capacity loads 16, entries are not cleared.
module ordered_array_table_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [oat_pkg::OP_BITS-1:0]    req_operation,
   input  logic [oat_pkg::ELEM_BITS-1:0]  req_element,
   input  logic [oat_pkg::POS_BITS-1:0]   req_position,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_ok,
   output logic [oat_pkg::FOUND_BITS-1:0] rsp_found_at,
   output logic [oat_pkg::CNT_BITS-1:0]   rsp_entry_count,
   input  logic                           csr_wr_en,
   input  logic [oat_pkg::CAP_BITS-1:0]   csr_wr_data
);

   oat_pkg::oat_cmd_type    cmd;
   oat_pkg::oat_status_type status;

   oat_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   oat_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_operation   (req_operation),
      .req_element     (req_element),
      .req_position    (req_position),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_ok          (rsp_ok),
      .rsp_found_at    (rsp_found_at),
      .rsp_entry_count (rsp_entry_count),
      .cmd             (cmd),
      .status          (status)
   );

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// Testbench for the ordered array table: directed list cases, then random operation traffic.
// Depends on oat_pkg and ordered_array_table_top; results are checked against an in-bench model.
module tb_top;

   localparam int CLOCK_PERIOD  = 8;
   localparam int QUIET_LIMIT   = 2000;
   localparam int RANDOM_PHASES = 13;
   localparam int PHASE_ITEMS   = 148;
   localparam int SETTLE_CYCLES = 4;
   localparam int TAIL_CYCLES   = 24;

   typedef struct packed {
      logic                           ok;
      logic [oat_pkg::FOUND_BITS-1:0] found_at;
      logic [oat_pkg::CNT_BITS-1:0]   entry_count;
   } table_result_type;

   logic                           clock         = 1'b0;
   logic                           reset         = 1'b1;
   logic                           req_valid     = 1'b0;
   logic                           req_stall;
   logic [oat_pkg::OP_BITS-1:0]    req_operation = oat_pkg::OP_APPEND;
   logic [oat_pkg::ELEM_BITS-1:0]  req_element   = '0;
   logic [oat_pkg::POS_BITS-1:0]   req_position  = '0;
   logic                           rsp_valid;
   logic                           rsp_stall     = 1'b0;
   logic                           rsp_ok;
   logic [oat_pkg::FOUND_BITS-1:0] rsp_found_at;
   logic [oat_pkg::CNT_BITS-1:0]   rsp_entry_count;
   logic                           csr_wr_en     = 1'b0;
   logic [oat_pkg::CAP_BITS-1:0]   csr_wr_data   = '0;

   // Shadow copy of the list and the capacity register.
   logic [oat_pkg::ENTRY_BITS-1:0] shadow_entries [oat_pkg::DEPTH];
   int unsigned                    shadow_count;
   int unsigned                    shadow_capacity;
   table_result_type               expected_results [$];
   int                             mismatch_count = 0;
   int                             idle_max       = 9;

   ordered_array_table_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_element     (req_element),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_ok          (rsp_ok),
      .rsp_found_at    (rsp_found_at),
      .rsp_entry_count (rsp_entry_count),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   function automatic table_result_type predict_operation(
         oat_pkg::op_type op, logic [oat_pkg::ELEM_BITS-1:0] elem,
         logic [oat_pkg::POS_BITS-1:0] pos);
      table_result_type               res;
      int unsigned                    room;
      int unsigned                    i;
      logic [oat_pkg::ENTRY_BITS-1:0] value;
      logic [oat_pkg::ENTRY_BITS-1:0] held;
      logic                           searching;
      res   = '0;
      value = oat_pkg::ENTRY_BITS'(elem);
      room  = (shadow_capacity > oat_pkg::DEPTH) ? oat_pkg::DEPTH : shadow_capacity;
      case (op)
         oat_pkg::OP_APPEND: begin
            if (shadow_count < room) begin
               shadow_entries[shadow_count] = value;
               shadow_count++;
               res.ok = 1'b1;
            end
         end
         oat_pkg::OP_INSERT: begin
            if (shadow_count < room && pos <= shadow_count) begin
               for (i = shadow_count; i > pos; i--) begin
                  shadow_entries[i] = shadow_entries[i-1];
               end
               shadow_entries[pos] = value;
               shadow_count++;
               res.ok = 1'b1;
            end
         end
         oat_pkg::OP_DELETE: begin
            if (pos < shadow_count) begin
               for (i = pos; i + 1 < shadow_count; i++) begin
                  shadow_entries[i] = shadow_entries[i+1];
               end
               shadow_count--;
               res.ok = 1'b1;
            end
         end
         default: begin
            // The first hit moves one place toward the front of the list.
            searching = 1'b1;
            i = 0;
            while (searching && i < shadow_count) begin
               if (shadow_entries[i] == value) begin
                  if (i > 0) begin
                     held                = shadow_entries[i];
                     shadow_entries[i]   = shadow_entries[i-1];
                     shadow_entries[i-1] = held;
                  end
                  res.ok       = 1'b1;
                  res.found_at = oat_pkg::FOUND_BITS'(i);
                  searching    = 1'b0;
               end else begin
                  i++;
               end
            end
         end
      endcase
      res.entry_count = oat_pkg::CNT_BITS'(shadow_count);
      return res;
   endfunction

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      $display("%0t: mismatch on %s: got %0h, expected %0h", $time, field, got, want);
      mismatch_count++;
   endtask

   // The transaction stays valid into the next call when that call draws no gap.
   task automatic send_operation(oat_pkg::op_type op, logic [oat_pkg::ELEM_BITS-1:0] elem,
                                 logic [oat_pkg::POS_BITS-1:0] pos);
      int gap;
      gap = $urandom_range(0, idle_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_element   <= elem;
      req_position  <= pos;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      expected_results.push_back(predict_operation(op, elem, pos));
   endtask

   task automatic wait_until_idle();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_capacity(logic [oat_pkg::CAP_BITS-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en       <= 1'b0;
      shadow_capacity = value;
   endtask

   task automatic test_empty_list();
      send_operation(oat_pkg::OP_SEARCH, 8'h00, 5'd0);
      send_operation(oat_pkg::OP_DELETE, 8'h00, 5'd0);
      send_operation(oat_pkg::OP_INSERT, 8'h11, 5'd1);
      send_operation(oat_pkg::OP_INSERT, 8'hFF, 5'd0);
      wait_until_idle();
   endtask

   task automatic test_insert_delete_bounds();
      send_operation(oat_pkg::OP_APPEND, 8'h00, 5'd31);
      send_operation(oat_pkg::OP_INSERT, 8'h81, 5'd1);
      send_operation(oat_pkg::OP_INSERT, 8'h7E, 5'd3);
      send_operation(oat_pkg::OP_INSERT, 8'h42, 5'd5);
      send_operation(oat_pkg::OP_DELETE, 8'h00, 5'd4);
      send_operation(oat_pkg::OP_DELETE, 8'hFF, 5'd31);
      send_operation(oat_pkg::OP_DELETE, 8'h00, 5'd1);
      wait_until_idle();
   endtask

   task automatic test_search_transpose();
      send_operation(oat_pkg::OP_SEARCH, 8'h7E, 5'd16);
      send_operation(oat_pkg::OP_SEARCH, 8'h7E, 5'd0);
      send_operation(oat_pkg::OP_SEARCH, 8'h7E, 5'd0);
      send_operation(oat_pkg::OP_SEARCH, 8'h55, 5'd0);
      wait_until_idle();
   endtask

   task automatic test_capacity_register();
      set_capacity(5'd0);
      send_operation(oat_pkg::OP_APPEND, 8'h01, 5'd0);
      send_operation(oat_pkg::OP_INSERT, 8'h02, 5'd0);
      send_operation(oat_pkg::OP_SEARCH, 8'hFF, 5'd0);
      send_operation(oat_pkg::OP_DELETE, 8'h00, 5'd2);
      wait_until_idle();
      // Capacity below the current count keeps the entries already there.
      set_capacity(5'd1);
      send_operation(oat_pkg::OP_APPEND, 8'h03, 5'd0);
      wait_until_idle();
      set_capacity(5'd3);
      send_operation(oat_pkg::OP_APPEND, 8'hA5, 5'd0);
      send_operation(oat_pkg::OP_APPEND, 8'h5A, 5'd0);
      wait_until_idle();
      set_capacity(5'd31);
      send_operation(oat_pkg::OP_INSERT, 8'hC3, 5'd3);
      wait_until_idle();
   endtask

   task automatic send_random_operation(bit growing);
      int                            pick;
      oat_pkg::op_type               op;
      logic [oat_pkg::ELEM_BITS-1:0] elem;
      logic [oat_pkg::POS_BITS-1:0]  pos;
      pick = $urandom_range(0, 99);
      elem = oat_pkg::ELEM_BITS'($urandom_range(0, 255));
      pos  = oat_pkg::POS_BITS'($urandom_range(0, 31));
      if (pick < 10) begin
         op = oat_pkg::op_type'($urandom_range(0, 3));
      end else begin
         pick = $urandom_range(0, 99);
         if (growing) begin
            op = (pick < 30) ? oat_pkg::OP_APPEND : (pick < 65) ? oat_pkg::OP_INSERT :
                 (pick < 75) ? oat_pkg::OP_DELETE : oat_pkg::OP_SEARCH;
         end else begin
            op = (pick < 10) ? oat_pkg::OP_APPEND : (pick < 25) ? oat_pkg::OP_INSERT :
                 (pick < 65) ? oat_pkg::OP_DELETE : oat_pkg::OP_SEARCH;
         end
         case (op)
            oat_pkg::OP_INSERT: begin
               pos = oat_pkg::POS_BITS'($urandom_range(0, shadow_count));
            end
            oat_pkg::OP_DELETE: begin
               pos = (shadow_count > 0) ?
                     oat_pkg::POS_BITS'($urandom_range(0, shadow_count - 1)) : '0;
            end
            oat_pkg::OP_SEARCH: begin
               if (shadow_count > 0 && $urandom_range(0, 3) != 0) begin
                  elem = shadow_entries[$urandom_range(0, shadow_count - 1)];
               end
            end
            default: ;
         endcase
         // A narrow value range makes duplicates common, so first-match order matters.
         if (op != oat_pkg::OP_SEARCH && $urandom_range(0, 3) == 0) begin
            elem = oat_pkg::ELEM_BITS'($urandom_range(0, 7));
         end
      end
      send_operation(op, elem, pos);
   endtask

   task automatic test_random_operations();
      logic [oat_pkg::CAP_BITS-1:0] caps [RANDOM_PHASES] = '{5'd16, 5'd31, 5'd0, 5'd16,
                                                             5'd4, 5'd1, 5'd20, 5'd16,
                                                             5'd9, 5'd2, 5'd31, 5'd16,
                                                             5'd12};
      logic [oat_pkg::CAP_BITS-1:0] cap;
      int                           phase;
      int                           n;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         cap = (phase == RANDOM_PHASES - 1) ? oat_pkg::CAP_BITS'($urandom) : caps[phase];
         set_capacity(cap);
         idle_max = (phase % 4 == 2) ? 0 : 9;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            // Swing between filling the list and emptying it.
            send_random_operation(((n / 37) % 2) == 0);
         end
         wait_until_idle();
      end
      idle_max = 9;
   endtask

   // Result side: hold off for a random number of cycles before each transaction.
   initial begin : result_backpressure
      int stall_cycles;
      forever begin
         stall_cycles = $urandom_range(0, idle_max);
         if (stall_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_cycles) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
      end
   end

   always @(posedge clock) begin : check_results
      table_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result", 32'd1, 32'd0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_ok !== want.ok) begin
               report_mismatch("ok", 32'(rsp_ok), 32'(want.ok));
            end
            if (rsp_found_at !== want.found_at) begin
               report_mismatch("found_at", 32'(rsp_found_at), 32'(want.found_at));
            end
            if (rsp_entry_count !== want.entry_count) begin
               report_mismatch("entry_count", 32'(rsp_entry_count), 32'(want.entry_count));
            end
         end
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid === 1'b1 && req_stall === 1'b0) ||
             (rsp_valid === 1'b1 && rsp_stall === 1'b0)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("tb_top: FAIL");
      $finish;
   end

   initial begin : run_tests
      int i;
      for (i = 0; i < oat_pkg::DEPTH; i++) shadow_entries[i] = '0;
      shadow_count    = 0;
      shadow_capacity = oat_pkg::CAP_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_empty_list();
      test_insert_delete_bounds();
      test_search_transpose();
      test_capacity_register();
      test_random_operations();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_results.size() != 0) begin
         report_mismatch("results left over", 32'(expected_results.size()), 32'd0);
      end
      if (mismatch_count == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
